/* hw/rtl/glcw_pkg.sv */
// Shared types and constants for the grid line cell walker.
package glcw_pkg;

  localparam int CELL_W    = 24;
  localparam int FIELD_W   = 32;
  localparam int CFG_IDX_W = 4;

  localparam logic [CELL_W-1:0]    RESET_CELL      = CELL_W'(1000000);
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = CFG_IDX_W'(1);

  // Division operand select
  localparam logic [1:0] OP_START_X = 2'd0;
  localparam logic [1:0] OP_START_Y = 2'd1;
  localparam logic [1:0] OP_END_X   = 2'd2;
  localparam logic [1:0] OP_END_Y   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_WB,
    S_MUL,
    S_WALK
  } glcw_state_t;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       div_wb;
    logic [1:0] op;
    logic       mul;
    logic       walk_step;
  } glcw_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic walk_last;
  } glcw_stat_t;

endpackage

/* hw/rtl/grid_line_cell_walker.sv */
// Top level of the grid line cell walker: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_ready  | in_start_x, in_start_y, in_end_x, in_end_y
//  out     | output    | out_valid/out_ready  | out_cell_x, out_cell_y, out_last_cell,
//          |           |                      | out_overflow
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// Sequence: one transaction in, then four floor divisions on one shared restoring
// divider (IN_BITS = min(COORD_BITS, 32)), a crossing-product step, then one cell
// per cycle while the output register is free. An item emits 1 to MAX_CELLS cells.
// Reset: rst_n is synchronous, active low; cell sizes return to 1000000.
// Stalls: the walk holds while a result sits unaccepted in the output register.
// A new segment is taken as soon as the last cell is in that register.
module grid_line_cell_walker
  import glcw_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int MAX_CELLS  = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [FIELD_W-1:0] in_start_x,
  input  logic signed [FIELD_W-1:0] in_start_y,
  input  logic signed [FIELD_W-1:0] in_end_x,
  input  logic signed [FIELD_W-1:0] in_end_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [FIELD_W-1:0] out_cell_x,
  output logic signed [FIELD_W-1:0] out_cell_y,
  output logic                      out_last_cell,
  output logic                      out_overflow,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CELL_W-1:0]         cfg_data
);

  glcw_cmd_t  cmd;
  glcw_stat_t stat;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  glcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  glcw_dp #(
    .COORD_BITS (COORD_BITS),
    .MAX_CELLS  (MAX_CELLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_last_cell (out_last_cell),
    .out_overflow  (out_overflow)
  );

endmodule

/* hw/rtl/glcw_ctrl.sv */
// Controller: sequences load, four divisions, product setup and the cell walk.
module glcw_ctrl
  import glcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  glcw_stat_t stat,
  output glcw_cmd_t  cmd
);

  glcw_state_t state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_START_X;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_START_X;
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DIV_WB;
        end
      end
      S_DIV_WB: begin
        cmd.div_wb = 1'b1;
        if (op_r == OP_END_Y) begin
          state_nxt = S_MUL;
        end else begin
          op_nxt    = op_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (stat.out_free) begin
          cmd.walk_step = 1'b1;
          if (stat.walk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/glcw_dp.sv */
// Datapath: config registers, serial divider, crossing products and cell stepper.
module glcw_dp
  import glcw_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int MAX_CELLS  = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  glcw_cmd_t                  cmd,
  output glcw_stat_t                 stat,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CELL_W-1:0]          cfg_data,
  input  logic signed [FIELD_W-1:0]  in_start_x,
  input  logic signed [FIELD_W-1:0]  in_start_y,
  input  logic signed [FIELD_W-1:0]  in_end_x,
  input  logic signed [FIELD_W-1:0]  in_end_y,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [FIELD_W-1:0]  out_cell_x,
  output logic signed [FIELD_W-1:0]  out_cell_y,
  output logic                       out_last_cell,
  output logic                       out_overflow
);

  localparam int IN_BITS = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int NX_W    = CELL_W + 1;
  localparam int PW      = CELL_W + IN_BITS + $clog2(MAX_CELLS) + 1;
  localparam int DCNT_W  = $clog2(IN_BITS);
  localparam int CNT_W   = $clog2(MAX_CELLS);
  localparam logic signed [IN_BITS-1:0] ONE = IN_BITS'(1);

  // configuration
  logic [CELL_W-1:0] cell_width_r, cell_height_r;
  logic [CELL_W-1:0] wd, hd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= RESET_CELL;
      cell_height_r <= RESET_CELL;
    end else if (cfg_we) begin
      if (cfg_index == REG_CELL_WIDTH) begin
        cell_width_r <= cfg_data;
      end else if (cfg_index == REG_CELL_HEIGHT) begin
        cell_height_r <= cfg_data;
      end
    end
  end

  // zero size reads as one
  assign wd = (cell_width_r  == '0) ? CELL_W'(1) : cell_width_r;
  assign hd = (cell_height_r == '0) ? CELL_W'(1) : cell_height_r;

  // segment capture
  logic signed [IN_BITS-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [IN_BITS-1:0]        ax_r, ay_r;
  logic                      stx_pos_r, sty_pos_r;
  logic signed [IN_BITS:0]   rx, ry;
  logic signed [IN_BITS-1:0] sx_in, sy_in, ex_in, ey_in;

  assign sx_in = $signed(in_start_x[IN_BITS-1:0]);
  assign sy_in = $signed(in_start_y[IN_BITS-1:0]);
  assign ex_in = $signed(in_end_x[IN_BITS-1:0]);
  assign ey_in = $signed(in_end_y[IN_BITS-1:0]);
  assign rx    = (IN_BITS+1)'(ex_in) - (IN_BITS+1)'(sx_in);
  assign ry    = (IN_BITS+1)'(ey_in) - (IN_BITS+1)'(sy_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r      <= sx_in;
      sy_r      <= sy_in;
      ex_r      <= ex_in;
      ey_r      <= ey_in;
      stx_pos_r <= ~rx[IN_BITS];
      sty_pos_r <= ~ry[IN_BITS];
      ax_r      <= rx[IN_BITS] ? IN_BITS'(-rx) : IN_BITS'(rx);
      ay_r      <= ry[IN_BITS] ? IN_BITS'(-ry) : IN_BITS'(ry);
    end
  end

  // restoring divider, one quotient bit per cycle on the magnitude
  logic signed [IN_BITS-1:0] opnd;
  logic [IN_BITS-1:0]        quo_r;
  logic [CELL_W-1:0]         rem_r, dvs_r;
  logic                      neg_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic [CELL_W:0]           trial;
  logic                      fits;

  always_comb begin
    case (cmd.op)
      OP_START_X: opnd = sx_r;
      OP_START_Y: opnd = sy_r;
      OP_END_X:   opnd = ex_r;
      OP_END_Y:   opnd = ey_r;
      default:    opnd = sx_r;
    endcase
  end

  assign trial = {rem_r, quo_r[IN_BITS-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_r  <= opnd[IN_BITS-1];
      quo_r  <= opnd[IN_BITS-1] ? IN_BITS'(-opnd) : IN_BITS'(opnd);
      rem_r  <= '0;
      dcnt_r <= '0;
      dvs_r  <= cmd.op[0] ? hd : wd;
    end else if (cmd.div_step) begin
      rem_r  <= fits ? CELL_W'(trial - {1'b0, dvs_r}) : CELL_W'(trial);
      quo_r  <= {quo_r[IN_BITS-2:0], fits};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
  end

  assign stat.div_last = (dcnt_r == DCNT_W'(IN_BITS - 1));

  // floor correction and boundary distance
  logic                      rem_nz;
  logic signed [IN_BITS-1:0] qf;
  logic [CELL_W-1:0]         rf;
  logic [NX_W-1:0]           nx_to_up, nx_to_dn;

  assign rem_nz   = (rem_r != '0);
  assign qf       = !neg_r ? $signed(quo_r) :
                    (rem_nz ? $signed(~quo_r) : $signed(IN_BITS'(-quo_r)));
  assign rf       = (neg_r && rem_nz) ? CELL_W'(dvs_r - rem_r) : rem_r;
  assign nx_to_up = NX_W'(dvs_r) - NX_W'(rf);
  assign nx_to_dn = NX_W'(rf);

  logic signed [IN_BITS-1:0] cx_r, cy_r, lx_r, ly_r;
  logic [NX_W-1:0]           nx_r, ny_r;
  logic [PW-1:0]             p_r, q_r, wa_r, hb_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      at_end, at_cap;

  assign at_end = (cx_r == lx_r) && (cy_r == ly_r);
  assign at_cap = (cnt_r == CNT_W'(MAX_CELLS - 1));
  assign stat.walk_last = at_end || at_cap;

  always_ff @(posedge clk) begin
    if (cmd.div_wb) begin
      case (cmd.op)
        OP_START_X: begin
          cx_r <= qf;
          nx_r <= stx_pos_r ? nx_to_up : nx_to_dn;
        end
        OP_START_Y: begin
          cy_r <= qf;
          ny_r <= sty_pos_r ? nx_to_up : nx_to_dn;
        end
        OP_END_X: lx_r <= qf;
        OP_END_Y: ly_r <= qf;
        default: ;
      endcase
    end else if (cmd.mul) begin
      // scaled crossing distances: nx/ax against ny/ay by cross-multiplying
      p_r   <= PW'(nx_r) * PW'(ay_r);
      q_r   <= PW'(ny_r) * PW'(ax_r);
      wa_r  <= PW'(wd) * PW'(ay_r);
      hb_r  <= PW'(hd) * PW'(ax_r);
      cnt_r <= '0;
    end else if (cmd.walk_step && !stat.walk_last) begin
      cnt_r <= cnt_r + CNT_W'(1);
      if (cx_r == lx_r) begin
        cy_r <= sty_pos_r ? cy_r + ONE : cy_r - ONE;
      end else if (cy_r == ly_r) begin
        cx_r <= stx_pos_r ? cx_r + ONE : cx_r - ONE;
      end else if (p_r < q_r) begin
        cx_r <= stx_pos_r ? cx_r + ONE : cx_r - ONE;
        p_r  <= p_r + wa_r;
      end else begin
        cy_r <= sty_pos_r ? cy_r + ONE : cy_r - ONE;
        q_r  <= q_r + hb_r;
      end
    end
  end

  // output register
  logic out_valid_r;

  assign stat.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.walk_step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_step) begin
      out_cell_x    <= FIELD_W'(cx_r);
      out_cell_y    <= FIELD_W'(cy_r);
      out_last_cell <= stat.walk_last;
      out_overflow  <= !at_end && at_cap;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* tb/tb.sv */
// Self-checking testbench for grid_line_cell_walker: directed table, then random segments.
`timescale 1ns / 1ps

module tb
  import glcw_pkg::*;
;

  localparam int HALF_PERIOD     = 4;         // 8 ns clock
  localparam int RESET_CYCLES    = 10;
  localparam int WALK_LIMIT      = 64;        // cells per segment before the walk is cut
  localparam int SETTLE_CYCLES   = 16;        // block is idle once its last cell is taken
  localparam int ITEMS_PER_SET   = 80;        // six grid settings, about 480 segments
  localparam int NUM_SETS        = 6;
  localparam int REPORT_LIMIT    = 10;
  localparam int WATCHDOG_CYCLES = 4_000_000;
  localparam int DIR_ROWS        = 18;

  // Index past the end of the register file; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);

  localparam logic signed [FIELD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [FIELD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam longint COORD_MIN = -longint'(32'h8000_0000);

  typedef struct packed {
    logic signed [FIELD_W-1:0] start_x;
    logic signed [FIELD_W-1:0] start_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] cell_x;
    logic signed [FIELD_W-1:0] cell_y;
    logic                      last_cell;
    logic                      overflow;
  } cell_t;

  typedef struct packed {
    seg_t  seg;
    logic  has_want;   // single-cell result typed in below
    cell_t want;
  } row_t;

  // Directed segments, all on the reset grid of 1000000 x 1000000.
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // degenerate: start and end in one cell, result readable at a glance
    '{'{32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
    '{'{-32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b1, '{-32'sd1, -32'sd1, 1'b1, 1'b0}},
    '{'{C_MAX, C_MAX, C_MAX, C_MAX}, 1'b1, '{32'sd2147, 32'sd2147, 1'b1, 1'b0}},
    '{'{C_MIN, C_MIN, C_MIN, C_MIN}, 1'b1, '{-32'sd2148, -32'sd2148, 1'b1, 1'b0}},
    '{'{32'sd0, 32'sd0, 32'sd999999, 32'sd999999}, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
    // short walks, both directions
    '{'{32'sd0, 32'sd0, 32'sd3500000, 32'sd1200000}, 1'b0, '0},
    '{'{32'sd3500000, 32'sd1200000, 32'sd0, 32'sd0}, 1'b0, '0},
    // start on a boundary while stepping negative
    '{'{32'sd2000000, 32'sd500000, -32'sd1500000, 32'sd700000}, 1'b0, '0},
    '{'{32'sd2000000, 32'sd3000000, 32'sd2000000, -32'sd2500000}, 1'b0, '0},
    // diagonals, the first through exact corners: ties go to y
    '{'{32'sd0, 32'sd0, 32'sd3000000, 32'sd3000000}, 1'b0, '0},
    '{'{-32'sd500000, -32'sd500000, 32'sd2500000, 32'sd1500000}, 1'b0, '0},
    // full-range spans, cut by the cell limit
    '{'{C_MIN, 32'sd0, C_MAX, 32'sd0}, 1'b0, '0},
    '{'{C_MIN, C_MIN, C_MAX, C_MAX}, 1'b0, '0},
    '{'{C_MAX, C_MIN, C_MIN, C_MAX}, 1'b0, '0},
    // exactly the limit, then one cell over it
    '{'{32'sd0, 32'sd0, 32'sd63500000, 32'sd0}, 1'b0, '0},
    '{'{32'sd0, 32'sd0, 32'sd64000000, 32'sd0}, 1'b0, '0},
    // across the origin
    '{'{-32'sd1, 32'sd0, 32'sd0, -32'sd1}, 1'b0, '0},
    '{'{32'sd1, 32'sd1, -32'sd1, -32'sd1}, 1'b0, '0}
  };

  // Grid settings per random phase: 0 stands for 1, the extremes on both axes.
  localparam logic [CELL_W-1:0] SET_WIDTH  [NUM_SETS] =
    '{24'd16777215, 24'd0, 24'd1, 24'd16777215, 24'd12345, 24'd1000000};
  localparam logic [CELL_W-1:0] SET_HEIGHT [NUM_SETS] =
    '{24'd16777215, 24'd1, 24'd16777215, 24'd7, 24'd678, 24'd1000000};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [FIELD_W-1:0] in_start_x = '0;
  logic signed [FIELD_W-1:0] in_start_y = '0;
  logic signed [FIELD_W-1:0] in_end_x = '0;
  logic signed [FIELD_W-1:0] in_end_y = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [FIELD_W-1:0] out_cell_x;
  logic signed [FIELD_W-1:0] out_cell_y;
  logic                      out_last_cell;
  logic                      out_overflow;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CELL_W-1:0]         cfg_data = '0;

  // Our copy of the grid registers, tracked on every accepted write.
  logic [CELL_W-1:0] grid_w = RESET_CELL;
  logic [CELL_W-1:0] grid_h = RESET_CELL;

  cell_t cells_due [$];   // cells still to come, oldest first
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  grid_line_cell_walker #(
    .COORD_BITS (32),
    .MAX_CELLS  (WALK_LIMIT)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_x    (in_start_x),
    .in_start_y    (in_start_y),
    .in_end_x      (in_end_x),
    .in_end_y      (in_end_y),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cell_x    (out_cell_x),
    .out_cell_y    (out_cell_y),
    .out_last_cell (out_last_cell),
    .out_overflow  (out_overflow),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Appends one cell to the tail of the expected queue.
  function automatic void queue_cell(input cell_t c);
    cells_due.insert(cells_due.size(), c);
  endfunction

  // Floor division; den is always positive here.
  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) < 0) q = q - 1;
    return q;
  endfunction

  // Zero-sized cells behave as size one.
  function automatic longint eff_size(input logic [CELL_W-1:0] size);
    return (size == '0) ? 64'sd1 : longint'(size);
  endfunction

  // Walks the segment cell by cell and queues every cell the block should emit.
  function automatic void predict_walk(input seg_t s);
    longint      w, h, sx, sy, ex, ey, rx, ry, stx, sty, cx, cy, lx, ly;
    logic [63:0] ax, ay, nx, ny;
    cell_t       walk [$];
    cell_t       c;
    logic        cut;
    w = eff_size(grid_w);
    h = eff_size(grid_h);
    sx = longint'(s.start_x);
    sy = longint'(s.start_y);
    ex = longint'(s.end_x);
    ey = longint'(s.end_y);
    rx = ex - sx;
    ry = ey - sy;
    stx = (rx >= 0) ? 64'sd1 : -64'sd1;
    sty = (ry >= 0) ? 64'sd1 : -64'sd1;
    cx = floor_quot(sx, w);
    cy = floor_quot(sy, h);
    lx = floor_quot(ex, w);
    ly = floor_quot(ey, h);
    ax = (rx < 0) ? -rx : rx;
    ay = (ry < 0) ? -ry : ry;
    // distance (in coordinate units) to the next boundary on each axis
    nx = (stx > 0) ? (cx + 1) * w - sx : sx - cx * w;
    ny = (sty > 0) ? (cy + 1) * h - sy : sy - cy * h;
    cut = 1'b0;
    c = '{cx[FIELD_W-1:0], cy[FIELD_W-1:0], 1'b0, 1'b0};
    walk.insert(walk.size(), c);
    while (cx != lx || cy != ly) begin
      if (walk.size() >= WALK_LIMIT) begin
        cut = 1'b1;
        break;
      end
      if (cx == lx) begin
        cy = cy + sty;
      end else if (cy == ly) begin
        cx = cx + stx;
      end else if (128'(nx) * 128'(ay) < 128'(ny) * 128'(ax)) begin
        // nx/ax < ny/ay, compared exactly by cross-multiplying
        cx = cx + stx;
        nx = nx + w;
      end else begin
        cy = cy + sty;
        ny = ny + h;
      end
      c = '{cx[FIELD_W-1:0], cy[FIELD_W-1:0], 1'b0, 1'b0};
      walk.insert(walk.size(), c);
    end
    walk[walk.size() - 1].last_cell = 1'b1;
    walk[walk.size() - 1].overflow  = cut;
    foreach (walk[i]) queue_cell(walk[i]);
  endfunction

  // Moves v down onto a cell boundary, staying inside the 32-bit range.
  function automatic longint snapped(input longint v, input longint size);
    longint q;
    q = floor_quot(v, size) * size;
    if (q < COORD_MIN) q = q + size;
    return q;
  endfunction

  // Mostly short walks of a few cells with random content; the rest is noise
  // that tends to run into the cell limit.
  function automatic seg_t random_segment();
    seg_t   s;
    longint w, h, sx, sy, dx, dy;
    w = eff_size(grid_w);
    h = eff_size(grid_h);
    sx = longint'($signed($urandom));
    sy = longint'($signed($urandom));
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 3) == 0) sx = snapped(sx, w);
      if ($urandom_range(0, 3) == 0) sy = snapped(sy, h);
      dx = longint'($urandom_range(0, 6)) * w + longint'($urandom_range(0, 32'(w - 1)));
      dy = longint'($urandom_range(0, 6)) * h + longint'($urandom_range(0, 32'(h - 1)));
      if ($urandom_range(0, 1) == 1) dx = -dx;
      if ($urandom_range(0, 1) == 1) dy = -dy;
      if ($urandom_range(0, 7) == 0) dx = 0;
      if ($urandom_range(0, 7) == 0) dy = 0;
      s.end_x = FIELD_W'(sx + dx);
      s.end_y = FIELD_W'(sy + dy);
    end else begin
      s.end_x = $urandom;
      s.end_y = $urandom;
    end
    s.start_x = sx[FIELD_W-1:0];
    s.start_y = sy[FIELD_W-1:0];
    return s;
  endfunction

  // Random gap before the next segment; valid drops only when a gap is taken.
  task automatic sender_gap();
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  // Presents one segment and holds it until the transaction completes.
  task automatic offer_segment(input seg_t s);
    in_valid   <= 1'b1;
    in_start_x <= s.start_x;
    in_start_y <= s.start_y;
    in_end_x   <= s.end_x;
    in_end_y   <= s.end_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds off new segments until every queued cell has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid is left high so back-to-back writes need no second drive.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CELL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_CELL_WIDTH) begin
      grid_w = val;
    end else if (idx == REG_CELL_HEIGHT) begin
      grid_h = val;
    end
  endtask

  // Idle mix: receiver-heavy gaps first, then sender-heavy, then none at all.
  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 31;
        recv_idle_pct = 65;
      end
      1: begin
        send_idle_pct = 65;
        recv_idle_pct = 31;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Result checker: each cell transaction against the oldest queued cell.
  always @(posedge clk) begin : cell_checker
    cell_t got;
    cell_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_cell_x, out_cell_y, out_last_cell, out_overflow};
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected cell (%0d,%0d) last %0b ovf %0b at %0t",
                   got.cell_x, got.cell_y, got.last_cell, got.overflow, $realtime);
      end else begin
        want = cells_due.pop_front();
        if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
            got.last_cell !== want.last_cell || got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch %0t: exp (%0d,%0d) l%0b o%0b, got (%0d,%0d) l%0b o%0b",
                     $realtime, want.cell_x, want.cell_y, want.last_cell, want.overflow,
                     got.cell_x, got.cell_y, got.last_cell, got.overflow);
        end
      end
    end
  end

  // Main sequence
  initial begin
    set_idle_mode(0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();

    // Directed table on the reset grid; typed rows bypass the predictor.
    for (int r = 0; r < DIR_ROWS; r++) begin
      sender_gap();
      offer_segment(DIR_TABLE[r].seg);
      if (DIR_TABLE[r].has_want) begin
        queue_cell(DIR_TABLE[r].want);
      end else begin
        predict_walk(DIR_TABLE[r].seg);
      end
    end

    // Random phases, one grid setting each, reprogrammed only when drained.
    for (int p = 0; p < NUM_SETS; p++) begin
      wait_drained();
      write_reg(REG_CELL_WIDTH, SET_WIDTH[p]);
      write_reg(REG_CELL_HEIGHT, SET_HEIGHT[p]);
      if (p == 4) write_reg(REG_SPARE, CELL_W'($urandom));
      cfg_valid <= 1'b0;
      @(posedge clk);
      set_idle_mode(p / 2);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        seg_t s;
        s = random_segment();
        sender_gap();
        offer_segment(s);
        predict_walk(s);
        // mid-phase hold-off: let the block run completely dry once
        if (p == 0 && i == ITEMS_PER_SET / 2) wait_drained();
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    #(2 * HALF_PERIOD * WATCHDOG_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* grid_line_cell_walker.f */
hw/rtl/glcw_pkg.sv
hw/rtl/glcw_ctrl.sv
hw/rtl/glcw_dp.sv
hw/rtl/grid_line_cell_walker.sv
tb/tb.sv
